FILE: hw/rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types, codes and fixed-point helpers shared by the postfix stack calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DEPTH_OUT_W = 7;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int DIV_W       = VALUE_WIDTH + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int WIDE_W      = PROD_W;

  localparam logic [WIDE_W-1:0] MAX_MAG =
    (WIDE_W'(1) << (VALUE_WIDTH - 1)) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] MIN_MAG = WIDE_W'(1) << (VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = MAX_MAG[VALUE_WIDTH-1:0];
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = MIN_MAG[VALUE_WIDTH-1:0];

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_OPER = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_R,
    S_POP_L,
    S_EXEC,
    S_MUL_END,
    S_DIV,
    S_DIV_END,
    S_STORE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                          action;
    logic signed [VALUE_WIDTH-1:0] operand_value;
    logic [1:0]                    operator_code;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic [1:0]                    status;
    logic [DEPTH_OUT_W-1:0]        stack_depth;
  } out_t;

  typedef struct packed {
    logic load;
    logic push;
    logic rd_right;
    logic pop_right;
    logic pop_left;
    logic exec;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    action_e action;
    op_e     op;
    logic    divisor_zero;
    logic    div_last;
    logic    out_free;
  } sts_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   sat;
  } sat_t;

  function automatic sat_t sat_mag(logic neg, logic [WIDE_W-1:0] mag);
    logic [WIDE_W-1:0] limit;
    logic [WIDE_W-1:0] clip;
    sat_t              r;
    limit = neg ? MIN_MAG : MAX_MAG;
    r.sat = (mag > limit);
    clip  = r.sat ? limit : mag;
    r.value = neg ? VALUE_WIDTH'(WIDE_W'(0) - clip) : clip[VALUE_WIDTH-1:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: steps each transaction through push, pops, execute and store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psc_pkg::sts_t   sts_i,
  output psc_pkg::cmd_t   cmd_o
);

  psc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      psc_pkg::S_IDLE: begin
        if (in_valid_i) state_d = psc_pkg::S_DISPATCH;
      end
      psc_pkg::S_DISPATCH: begin
        if (sts_i.action == psc_pkg::ACT_PUSH) state_d = psc_pkg::S_FINISH;
        else state_d = psc_pkg::S_POP_R;
      end
      psc_pkg::S_POP_R:   state_d = psc_pkg::S_POP_L;
      psc_pkg::S_POP_L:   state_d = psc_pkg::S_EXEC;
      psc_pkg::S_EXEC: begin
        unique case (sts_i.op)
          psc_pkg::OP_MUL: state_d = psc_pkg::S_MUL_END;
          psc_pkg::OP_DIV: begin
            if (sts_i.divisor_zero) state_d = psc_pkg::S_STORE;
            else state_d = psc_pkg::S_DIV;
          end
          default: state_d = psc_pkg::S_STORE;
        endcase
      end
      psc_pkg::S_MUL_END: state_d = psc_pkg::S_STORE;
      psc_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = psc_pkg::S_DIV_END;
      end
      psc_pkg::S_DIV_END: state_d = psc_pkg::S_STORE;
      psc_pkg::S_STORE:   state_d = psc_pkg::S_FINISH;
      psc_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = psc_pkg::S_IDLE;
      end
      default: state_d = psc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      psc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      psc_pkg::S_DISPATCH: begin
        if (sts_i.action == psc_pkg::ACT_PUSH) cmd_o.push = 1'b1;
        else cmd_o.rd_right = 1'b1;
      end
      psc_pkg::S_POP_R:   cmd_o.pop_right = 1'b1;
      psc_pkg::S_POP_L:   cmd_o.pop_left  = 1'b1;
      psc_pkg::S_EXEC:    cmd_o.exec      = 1'b1;
      psc_pkg::S_MUL_END: cmd_o.mul_fin   = 1'b1;
      psc_pkg::S_DIV:     cmd_o.div_step  = 1'b1;
      psc_pkg::S_DIV_END: cmd_o.div_fin   = 1'b1;
      psc_pkg::S_STORE:   cmd_o.store     = 1'b1;
      psc_pkg::S_FINISH:  cmd_o.emit      = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/psc_dpath.sv
// ----------------------------------------------------------------------------
// psc_dpath
// Operand stack memory, fixed-point arithmetic, serial divider, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psc_dpath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psc_pkg::in_t   in_data_i,
  input  psc_pkg::cmd_t  cmd_i,
  output psc_pkg::sts_t  sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output psc_pkg::out_t  out_data_o
);

  localparam int VW     = psc_pkg::VALUE_WIDTH;
  localparam int FB     = psc_pkg::FRAC_BITS;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [VW-1:0]    stack_mem [STACK_DEPTH];
  logic [VW-1:0]    rdata_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  psc_pkg::out_t    out_q;

  psc_pkg::in_t     item_q;
  logic [VW-1:0]    right_q, left_q, result_q;
  psc_pkg::status_e status_q;
  logic [psc_pkg::PROD_W-1:0]    prod_q;
  logic                          neg_q;
  logic [psc_pkg::DIV_W-1:0]     num_q;
  logic [VW-1:0]                 rem_q;
  logic [psc_pkg::DIV_CNT_W-1:0] div_cnt_q;

  logic             full;
  logic             mem_we;
  logic [VW-1:0]    mem_wdata;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [VW-1:0]    mag_l, mag_r;
  logic [VW:0]      sum;
  logic             sum_ovf;
  logic [VW:0]      rem_sh;
  logic             q_bit;
  psc_pkg::sat_t    mul_sat, div_sat;

  assign full      = (count_q == CNT_W'(STACK_DEPTH));
  assign waddr     = count_q[ADDR_W-1:0];
  assign raddr     = cmd_i.rd_right ? ADDR_W'(count_q - CNT_W'(1))
                                    : ADDR_W'(count_q - CNT_W'(2));
  assign mem_we    = (cmd_i.push && !full) || cmd_i.store;
  assign mem_wdata = cmd_i.push ? item_q.operand_value : result_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[waddr] <= mem_wdata;
    if (cmd_i.rd_right || cmd_i.pop_right) rdata_q <= stack_mem[raddr];
  end

  // arithmetic
  assign mag_l = left_q[VW-1]  ? (~left_q + VW'(1))  : left_q;
  assign mag_r = right_q[VW-1] ? (~right_q + VW'(1)) : right_q;
  assign sum   = (psc_pkg::op_e'(item_q.operator_code) == psc_pkg::OP_SUB)
               ? ({left_q[VW-1], left_q} - {right_q[VW-1], right_q})
               : ({left_q[VW-1], left_q} + {right_q[VW-1], right_q});
  assign sum_ovf = sum[VW] ^ sum[VW-1];

  assign mul_sat = psc_pkg::sat_mag(neg_q, prod_q >> FB);
  assign div_sat = psc_pkg::sat_mag(neg_q, psc_pkg::WIDE_W'(num_q));

  assign rem_sh = {rem_q, num_q[psc_pkg::DIV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, right_q[VW-1] ? mag_r : right_q});

  always_comb begin
    count_d = count_q;
    if (cmd_i.push && !full) count_d = count_q + CNT_W'(1);
    if (cmd_i.pop_left) count_d = (count_q >= CNT_W'(2)) ? count_q - CNT_W'(2) : '0;
    if (cmd_i.store) count_d = count_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.push) begin
      result_q <= full ? '0 : item_q.operand_value;
      status_q <= full ? psc_pkg::ST_OVERFLOW : psc_pkg::ST_OK;
    end
    if (cmd_i.pop_right) right_q <= (count_q != '0) ? rdata_q : '0;
    if (cmd_i.pop_left)  left_q  <= (count_q >= CNT_W'(2)) ? rdata_q : '0;
    if (cmd_i.exec) begin
      neg_q     <= left_q[VW-1] ^ right_q[VW-1];
      prod_q    <= mag_l * mag_r;
      num_q     <= {mag_l, {FB{1'b0}}};
      rem_q     <= '0;
      div_cnt_q <= psc_pkg::DIV_CNT_W'(psc_pkg::DIV_W - 1);
      unique case (psc_pkg::op_e'(item_q.operator_code))
        psc_pkg::OP_ADD, psc_pkg::OP_SUB: begin
          result_q <= sum_ovf ? (sum[VW] ? psc_pkg::VAL_MIN : psc_pkg::VAL_MAX)
                              : sum[VW-1:0];
          status_q <= sum_ovf ? psc_pkg::ST_SAT : psc_pkg::ST_OK;
        end
        psc_pkg::OP_DIV: begin
          result_q <= left_q[VW-1] ? psc_pkg::VAL_MIN : psc_pkg::VAL_MAX;
          status_q <= psc_pkg::ST_DIVZERO;
        end
        default: ;
      endcase
    end
    if (cmd_i.mul_fin) begin
      result_q <= mul_sat.value;
      status_q <= mul_sat.sat ? psc_pkg::ST_SAT : psc_pkg::ST_OK;
    end
    if (cmd_i.div_step) begin
      rem_q     <= q_bit ? VW'(rem_sh - {1'b0, mag_r}) : rem_sh[VW-1:0];
      num_q     <= {num_q[psc_pkg::DIV_W-2:0], q_bit};
      div_cnt_q <= div_cnt_q - psc_pkg::DIV_CNT_W'(1);
    end
    if (cmd_i.div_fin) begin
      result_q <= div_sat.value;
      status_q <= div_sat.sat ? psc_pkg::ST_SAT : psc_pkg::ST_OK;
    end
    if (cmd_i.emit) begin
      out_q.top_value   <= result_q;
      out_q.status      <= status_q;
      out_q.stack_depth <= psc_pkg::DEPTH_OUT_W'(count_q);
    end
  end

  assign sts_o.action       = psc_pkg::action_e'(item_q.action);
  assign sts_o.op           = psc_pkg::op_e'(item_q.operator_code);
  assign sts_o.divisor_zero = (right_q == '0);
  assign sts_o.div_last     = (div_cnt_q == '0);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/postfix_stack_calculator.sv
// ----------------------------------------------------------------------------
// postfix_stack_calculator
// Postfix (RPN) evaluator over an operand stack in signed Q16.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i): each transaction either
// pushes operand_value or applies operator_code (add, subtract, multiply,
// divide) to the two top entries, reading zero for an empty stack.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction per
// input with the value pushed, a status code and the resulting stack depth.
// Steps from input acceptance to output valid: a push runs dispatch and finish;
//   add/subtract run dispatch, both pops, execute, store, finish; multiply
//   adds a product step; divide by zero skips the divider; divide adds a
//   restoring divider (one quotient bit per cycle over 48 bits) and a final
//   step. With one write and one read stack port the two pops are serial.
// One transaction is in flight at a time; in_ready_o is high only when idle,
// so the next input is taken at the earliest in the cycle after a result
// is issued.
// A finished result sits in the output register while the next input is
// taken; if the receiver stalls, the next result waits until it drains.
// Reset empties the stack (count cleared) and drops any pending output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_stack_calculator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  psc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output psc_pkg::out_t out_data_o
);

  psc_pkg::cmd_t cmd;
  psc_pkg::sts_t sts;

  psc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
